@@ hdl/obstacle_avoid_drive_controller_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef OBSTACLE_AVOID_DRIVE_CONTROLLER_UNIT_ASSERT_SVH
`define OBSTACLE_AVOID_DRIVE_CONTROLLER_UNIT_ASSERT_SVH

// same-cycle implication
`define OADC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("oadc assertion failed");

// next-cycle implication
`define OADC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("oadc assertion failed");

`endif

@@ hdl/oadc_pkg.sv @@
// ----------------------------------------------------------------------------
// oadc_pkg
// Constants, codes and control types of the drive controller.
// ----------------------------------------------------------------------------
package oadc_pkg;

	localparam int GRANULARITY_DEG = 6;
	localparam int SCAN_STEP_DEG   = 12;
	localparam int MAP_ENTRIES     = 32;
	localparam int DECEL_STEP      = 100;
	localparam int AW              = $clog2(MAP_ENTRIES);
	localparam int RECIP           = (1 << 16) / GRANULARITY_DEG + 1;

	localparam int RW = 12;
	localparam int SW = 13;

	localparam logic [5:0] WARM_COUNT = 6'd32;
	localparam logic [SW-1:0] SPEED_SAT = 13'd255;

	localparam logic [7:0] CH_R = 8'h52;
	localparam logic [7:0] CH_F = 8'h46;
	localparam logic [7:0] CH_C = 8'h43;
	localparam logic [7:0] CH_L = 8'h4C;
	localparam logic [7:0] CH_N = 8'h4E;

	localparam logic [1:0] OP_RADAR  = 2'd0;
	localparam logic [1:0] OP_PLAN   = 2'd1;
	localparam logic [1:0] OP_RAMP   = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [1:0] STEER_NONE  = 2'd0;
	localparam logic [1:0] STEER_LEFT  = 2'd1;
	localparam logic [1:0] STEER_RIGHT = 2'd2;

	localparam logic [3:0] CFG_MAN_AHEAD  = 4'd0;
	localparam logic [3:0] CFG_MAN_BEHIND = 4'd1;
	localparam logic [3:0] CFG_STOP_AHEAD = 4'd2;
	localparam logic [3:0] CFG_STOP_BEHIND = 4'd3;
	localparam logic [3:0] CFG_HYST       = 4'd4;
	localparam logic [3:0] CFG_LOW_SPEED  = 4'd5;
	localparam logic [3:0] CFG_HIGH_SPEED = 4'd6;
	localparam logic [3:0] CFG_ACCEL      = 4'd7;

	localparam logic [2:0] SLOT_LAST = 3'd4;

	typedef struct packed {
		logic          take;
		logic          exec;
		logic          rd_en;
		logic [2:0]    rd_slot;
		logic          route;
		logic          check;
		logic          load;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       warm_done;
	} sts_t;

	// map index of a scan angle given in scan steps, clamped to the map
	function automatic int scan_idx(input int steps);
		int a;
		int idx;
		a = steps * SCAN_STEP_DEG;
		if (a < -90) a = -90;
		if (a > 90) a = 90;
		idx = (90 - a) / GRANULARITY_DEG;
		if (idx >= MAP_ENTRIES) idx = MAP_ENTRIES - 1;
		return idx;
	endfunction

	localparam logic [AW-1:0] SLOT_ADDR_L2 = AW'(scan_idx(-2));
	localparam logic [AW-1:0] SLOT_ADDR_L1 = AW'(scan_idx(-1));
	localparam logic [AW-1:0] SLOT_ADDR_D0 = AW'(scan_idx(0));
	localparam logic [AW-1:0] SLOT_ADDR_R1 = AW'(scan_idx(1));
	localparam logic [AW-1:0] SLOT_ADDR_R2 = AW'(scan_idx(2));

	// map address of scan slot (slot 2 is straight ahead)
	function automatic logic [AW-1:0] slot_addr(input logic [2:0] slot);
		logic [AW-1:0] r;
		case (slot)
			3'd0:    r = SLOT_ADDR_L2;
			3'd1:    r = SLOT_ADDR_L1;
			3'd2:    r = SLOT_ADDR_D0;
			3'd3:    r = SLOT_ADDR_R1;
			default: r = SLOT_ADDR_R2;
		endcase
		return r;
	endfunction

endpackage

@@ hdl/oadc_in_if.sv @@
// ----------------------------------------------------------------------------
// oadc_in_if
// Input item channel: operation and message.
// ----------------------------------------------------------------------------
interface oadc_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [31:0] message;
	modport source (output valid, output operation, output message, input ready);
	modport sink (input valid, input operation, input message, output ready);
endinterface

@@ hdl/oadc_out_if.sv @@
// ----------------------------------------------------------------------------
// oadc_out_if
// Result item channel: status word and drive state.
// ----------------------------------------------------------------------------
interface oadc_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] status_word;
	logic        status_valid;
	logic [12:0] pwm_level;
	logic        drive_reverse;
	logic [1:0]  steer_state;
	logic        emergency;
	logic        warming_up;
	logic        motor_stopped;
	logic        braking;
	modport source (output valid, output status_word, output status_valid,
		output pwm_level, output drive_reverse, output steer_state, output emergency,
		output warming_up, output motor_stopped, output braking, input ready);
	modport sink (input valid, input status_word, input status_valid,
		input pwm_level, input drive_reverse, input steer_state, input emergency,
		input warming_up, input motor_stopped, input braking, output ready);
endinterface

@@ hdl/oadc_cfg_if.sv @@
// ----------------------------------------------------------------------------
// oadc_cfg_if
// Configuration write channel: register index and data.
// ----------------------------------------------------------------------------
interface oadc_cfg_if;
	logic        valid;
	logic        ready;
	logic [3:0]  index;
	logic [12:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ hdl/oadc_ctrl.sv @@
// ----------------------------------------------------------------------------
// oadc_ctrl
// Sequencer: accept, execute, map reads, route, check, result transfer.
// ----------------------------------------------------------------------------
module oadc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  oadc_pkg::sts_t sts,
	output oadc_pkg::cmd_t cmd
);
	import oadc_pkg::*;

	`include "obstacle_avoid_drive_controller_unit_assert.svh"

	typedef enum logic [2:0] {
		S_IDLE, S_EXEC, S_RD, S_RDW, S_ROUTE, S_CHECK, S_FIN
	} state_t;

	state_t     state_q;
	logic [2:0] cnt_q;
	logic       out_valid_q;
	logic       load;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign load      = (state_q == S_FIN) && (!out_valid_q || out_ready);

	always_comb begin
		cmd         = '0;
		cmd.take    = in_valid && in_ready;
		cmd.exec    = (state_q == S_EXEC);
		cmd.rd_en   = (state_q == S_RD);
		cmd.rd_slot = cnt_q;
		cmd.route   = (state_q == S_ROUTE);
		cmd.check   = (state_q == S_CHECK);
		cmd.load    = load;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_EXEC;
				end
				S_EXEC: begin
					cnt_q <= '0;
					if (sts.op == OP_PLAN && sts.warm_done) state_q <= S_RD;
					else state_q <= S_FIN;
				end
				S_RD: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == SLOT_LAST) state_q <= S_RDW;
				end
				S_RDW:   state_q <= S_ROUTE;
				S_ROUTE: state_q <= S_CHECK;
				S_CHECK: state_q <= S_FIN;
				S_FIN: begin
					if (load) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`OADC_ASSERT_NXT(a_take_exec, cmd.take, state_q == S_EXEC)
	`OADC_ASSERT_NXT(a_load_valid, load, out_valid_q)
	`OADC_ASSERT_NXT(a_rd_done, (state_q == S_RD) && (cnt_q == SLOT_LAST), state_q == S_RDW)

endmodule

@@ hdl/oadc_dp.sv @@
// ----------------------------------------------------------------------------
// oadc_dp
// Datapath: range maps, drive state, planning logic, result register.
// ----------------------------------------------------------------------------
module oadc_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  oadc_pkg::cmd_t cmd,
	output oadc_pkg::sts_t sts,
	input  logic [1:0]     operation,
	input  logic [31:0]    message,
	input  logic           cfg_we,
	input  logic [3:0]     cfg_index,
	input  logic [12:0]    cfg_data,
	output logic [31:0]    status_word,
	output logic           status_valid,
	output logic [12:0]    pwm_level,
	output logic           drive_reverse,
	output logic [1:0]     steer_state,
	output logic           emergency,
	output logic           warming_up,
	output logic           motor_stopped,
	output logic           braking
);
	import oadc_pkg::*;

	logic [1:0]  op_q;
	logic [31:0] msg_q;
	logic [RW-1:0] man_a_q, man_b_q, stop_a_q, stop_b_q, hyst_q;
	logic [SW-1:0] low_q, high_q, accel_q;

	logic [RW-1:0] fmem [MAP_ENTRIES];
	logic [RW-1:0] rmem [MAP_ENTRIES];
	logic [MAP_ENTRIES-1:0] fvld_q, rvld_q;
	logic [RW-1:0] frd_s1, rrd_s1;
	logic          fvrd_s1, rvrd_s1, rdv_s1;
	logic [2:0]    slot_s1;
	logic [4:0][RW-1:0] fv_q, rv_q;

	logic          rev_q, pend_q, emerg_q, statv_q;
	logic [1:0]    steer_q;
	logic [SW-1:0] now_q, goal_q;
	logic [5:0]    tally_q;
	logic [31:0]   stat_q;

	logic [24:0]   prod;
	logic [8:0]    qidx;
	logic [AW-1:0] waddr, raddr;
	logic          is_radar, we_f, we_r;
	logic [RW-1:0] rng;

	function automatic logic obst(input logic [4:0][RW-1:0] v, input logic behind,
		input logic [1:0] s, input logic [RW-1:0] lim);
		logic [2:0] lo;
		lo = 3'd1;
		if (s == STEER_LEFT) lo = behind ? 3'd2 : 3'd0;
		if (s == STEER_RIGHT) lo = behind ? 3'd0 : 3'd2;
		return (v[lo] < lim) || (v[lo + 3'd1] < lim) || (v[lo + 3'd2] < lim);
	endfunction

	// radar word decode
	assign prod     = {17'd0, msg_q[15:8]} * 25'(RECIP);
	assign qidx     = prod[24:16];
	assign waddr    = qidx[AW-1:0];
	assign is_radar = (op_q == OP_RADAR) && (msg_q[31:24] == CH_R)
		&& (32'(qidx) < 32'(MAP_ENTRIES));
	assign we_f     = cmd.exec && is_radar && (msg_q[23:16] == CH_F);
	assign we_r     = cmd.exec && is_radar && (msg_q[23:16] == CH_R);
	assign rng      = RW'(msg_q[7:0]) * 12'd10;
	assign raddr    = slot_addr(cmd.rd_slot);

	always_ff @(posedge clk) begin
		if (we_f) fmem[waddr] <= rng;
		if (we_r) rmem[waddr] <= rng;
		frd_s1 <= fmem[raddr];
		rrd_s1 <= rmem[raddr];
	end

	// ramp
	logic [SW:0]   up_sum;
	logic [SW-1:0] ramp_now;
	assign up_sum = {1'b0, now_q} + {1'b0, accel_q};
	always_comb begin
		ramp_now = now_q;
		if (now_q < goal_q) begin
			ramp_now = (up_sum > {1'b0, goal_q}) ? goal_q : up_sum[SW-1:0];
		end else if (now_q > goal_q) begin
			ramp_now = (now_q < SW'(DECEL_STEP)) ? '0 : now_q - SW'(DECEL_STEP);
		end
	end

	// route planning
	logic          ob_fa, ob_rb, fwd, tgt, rev1, pend1;
	logic [1:0]    s1, s2;
	logic [SW-1:0] goal1;
	logic [5:0]    tally1;
	logic [4:0][RW-1:0] m;
	logic [SW-1:0] d0, l1, l2, r1, r2, a, b, h;
	always_comb begin
		fwd    = !rev_q;
		ob_fa  = obst(fv_q, 1'b0, steer_q, man_a_q);
		ob_rb  = obst(rv_q, 1'b1, steer_q, man_b_q);
		s1     = steer_q;
		rev1   = rev_q;
		goal1  = goal_q;
		pend1  = pend_q;
		tally1 = tally_q;
		tgt    = fwd && !ob_rb;
		if (fwd ? ob_fa : ob_rb) begin
			if (s1 != STEER_NONE) begin
				s1    = STEER_NONE;
				pend1 = 1'b1;
			end
			if (rev_q != tgt) begin
				if (now_q != '0) begin
					goal1 = '0;
				end else begin
					rev1   = tgt;
					pend1  = 1'b1;
					tally1 = '0;
				end
			end
		end
		m  = rev1 ? rv_q : fv_q;
		h  = {1'b0, hyst_q};
		d0 = {1'b0, m[2]};
		l1 = {1'b0, m[1]};
		l2 = {1'b0, m[0]};
		r1 = {1'b0, m[3]};
		r2 = {1'b0, m[4]};
		s2 = s1;
		a  = rev1 ? r1 : l1;
		b  = rev1 ? r2 : l2;
		if (s1 == STEER_RIGHT) begin
			a = rev1 ? l1 : r1;
			b = rev1 ? l2 : r2;
		end
		case (s1)
			STEER_LEFT, STEER_RIGHT: begin
				if (d0 > a + h && d0 > b + h) begin
					s2    = STEER_NONE;
					pend1 = 1'b1;
				end
			end
			STEER_NONE: begin
				if (r1 > d0 + h && r1 > l1 + h) begin
					s2    = rev1 ? STEER_LEFT : STEER_RIGHT;
					pend1 = 1'b1;
				end else if (l1 > d0 + h && l1 > r1 + h) begin
					s2    = rev1 ? STEER_RIGHT : STEER_LEFT;
					pend1 = 1'b1;
				end
			end
			default: s2 = s1;
		endcase
	end

	// collision check and speed planning
	logic          hit, ob_sp;
	logic [SW-1:0] req;
	always_comb begin
		hit   = rev_q ? obst(rv_q, 1'b1, steer_q, stop_b_q)
			: obst(fv_q, 1'b0, steer_q, stop_a_q);
		ob_sp = rev_q ? obst(rv_q, 1'b1, steer_q, man_b_q)
			: obst(fv_q, 1'b0, steer_q, man_a_q);
		req   = ob_sp ? '0 : (steer_q != STEER_NONE) ? low_q : high_q;
	end

	logic [7:0] sc;
	logic [7:0] sat;
	assign sc  = (steer_q == STEER_LEFT) ? CH_L : (steer_q == STEER_RIGHT) ? CH_R : CH_N;
	assign sat = (now_q > SPEED_SAT) ? 8'hFF : now_q[7:0];

	assign sts.op        = op_q;
	assign sts.warm_done = (tally_q >= WARM_COUNT);

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			op_q  <= operation;
			msg_q <= message;
		end
		if (rdv_s1) begin
			fv_q[slot_s1] <= fvrd_s1 ? frd_s1 : '0;
			rv_q[slot_s1] <= rvrd_s1 ? rrd_s1 : '0;
		end
		slot_s1 <= cmd.rd_slot;
		if (cmd.load) begin
			status_word   <= stat_q;
			status_valid  <= statv_q;
			pwm_level     <= now_q;
			drive_reverse <= rev_q;
			steer_state   <= steer_q;
			emergency     <= emerg_q;
			warming_up    <= (tally_q < WARM_COUNT);
			motor_stopped <= (now_q == '0);
			braking       <= (now_q > goal_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			man_a_q  <= 12'd60;
			man_b_q  <= 12'd60;
			stop_a_q <= 12'd20;
			stop_b_q <= 12'd20;
			hyst_q   <= 12'd20;
			low_q    <= 13'd2000;
			high_q   <= 13'd4000;
			accel_q  <= 13'd50;
			fvld_q   <= '0;
			rvld_q   <= '0;
			fvrd_s1  <= 1'b0;
			rvrd_s1  <= 1'b0;
			rdv_s1   <= 1'b0;
			rev_q    <= 1'b0;
			steer_q  <= STEER_NONE;
			now_q    <= '0;
			goal_q   <= '0;
			tally_q  <= '0;
			pend_q   <= 1'b1;
			emerg_q  <= 1'b0;
			statv_q  <= 1'b0;
			stat_q   <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_MAN_AHEAD:   man_a_q  <= cfg_data[RW-1:0];
					CFG_MAN_BEHIND:  man_b_q  <= cfg_data[RW-1:0];
					CFG_STOP_AHEAD:  stop_a_q <= cfg_data[RW-1:0];
					CFG_STOP_BEHIND: stop_b_q <= cfg_data[RW-1:0];
					CFG_HYST:        hyst_q   <= cfg_data[RW-1:0];
					CFG_LOW_SPEED:   low_q    <= cfg_data;
					CFG_HIGH_SPEED:  high_q   <= cfg_data;
					CFG_ACCEL:       accel_q  <= cfg_data;
					default: ;
				endcase
			end
			fvrd_s1 <= fvld_q[raddr];
			rvrd_s1 <= rvld_q[raddr];
			rdv_s1  <= cmd.rd_en;
			if (we_f) fvld_q[waddr] <= 1'b1;
			if (we_r) rvld_q[waddr] <= 1'b1;
			if (cmd.exec) begin
				emerg_q <= 1'b0;
				statv_q <= 1'b0;
				stat_q  <= '0;
				case (op_q)
					OP_RADAR: begin
						if (tally_q < WARM_COUNT) tally_q <= tally_q + 6'd1;
					end
					OP_PLAN: begin
						if (pend_q) begin
							statv_q <= 1'b1;
							stat_q  <= {CH_C, rev_q ? CH_R : CH_F, sc, sat};
							pend_q  <= 1'b0;
						end
					end
					OP_RAMP: begin
						now_q <= ramp_now;
						if (now_q != goal_q) pend_q <= 1'b1;
					end
					default: ;
				endcase
			end
			if (cmd.route) begin
				steer_q <= s2;
				rev_q   <= rev1;
				goal_q  <= goal1;
				pend_q  <= pend1;
				tally_q <= tally1;
			end
			if (cmd.check) begin
				if (hit) begin
					pend_q  <= 1'b1;
					rev_q   <= 1'b0;
					steer_q <= STEER_NONE;
					now_q   <= '0;
					goal_q  <= '0;
					fvld_q  <= '0;
					rvld_q  <= '0;
					tally_q <= '0;
					emerg_q <= 1'b1;
				end else if (req != now_q) begin
					goal_q <= req;
				end
			end
		end
	end

endmodule

@@ hdl/obstacle_avoid_drive_controller_unit.sv @@
// ----------------------------------------------------------------------------
// obstacle_avoid_drive_controller_unit
// Radar map keeper and drive planner with speed ramp.
// ----------------------------------------------------------------------------
// Items are handled one at a time. A radar word, a ramp tick, an unused
// operation or a plan tick during warm-up goes from execute straight to the
// result register; a plan tick with a full message tally first reads the five
// scan slots of both range maps in turn through one registered read port per
// map, then takes a route step and a collision/speed step. A new item
// is taken while the previous result waits in the output register. Map
// clearing (reset or hard stop) is immediate via per-entry valid bits;
// there is no clearing pass. Configuration writes are always ready.
module obstacle_avoid_drive_controller_unit (
	input  logic clk,
	input  logic arst_n,
	oadc_in_if.sink    in_ch,
	oadc_out_if.source out_ch,
	oadc_cfg_if.sink   cfg_ch
);
	import oadc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ch.ready = 1'b1;

	oadc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	oadc_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.operation     (in_ch.operation),
		.message       (in_ch.message),
		.cfg_we        (cfg_ch.valid),
		.cfg_index     (cfg_ch.index),
		.cfg_data      (cfg_ch.data),
		.status_word   (out_ch.status_word),
		.status_valid  (out_ch.status_valid),
		.pwm_level     (out_ch.pwm_level),
		.drive_reverse (out_ch.drive_reverse),
		.steer_state   (out_ch.steer_state),
		.emergency     (out_ch.emergency),
		.warming_up    (out_ch.warming_up),
		.motor_stopped (out_ch.motor_stopped),
		.braking       (out_ch.braking)
	);

endmodule

@@ sim/oadc_tb_if.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// oadc_tb_if
// Testbench package: result type and scoreboard of the drive controller.
// ----------------------------------------------------------------------------
package oadc_tb_pkg;
	import oadc_pkg::*;

	typedef struct packed {
		logic [31:0] status_word;
		logic        status_valid;
		logic [12:0] pwm_level;
		logic        drive_reverse;
		logic [1:0]  steer_state;
		logic        emergency;
		logic        warming_up;
		logic        motor_stopped;
		logic        braking;
	} drive_res_t;

	class drive_scoreboard;
		int unsigned cfg_val [8];
		int unsigned front_map [MAP_ENTRIES];
		int unsigned rear_map [MAP_ENTRIES];
		bit          reverse;
		logic [1:0]  steer;
		int unsigned speed_now, speed_goal, tally;
		bit          pending;
		drive_res_t  pending_res [$];
		int          mismatches;

		function new();
			cfg_val = '{60, 60, 20, 20, 20, 2000, 4000, 50};
			foreach (front_map[i]) begin
				front_map[i] = 0;
				rear_map[i] = 0;
			end
			reverse = 0;
			steer = STEER_NONE;
			speed_now = 0;
			speed_goal = 0;
			tally = 0;
			pending = 1;
			mismatches = 0;
		endfunction

		function void write_cfg(int idx, int unsigned v);
			cfg_val[idx] = (idx < 5) ? (v & 12'hFFF) : (v & 13'h1FFF);
		endfunction

		function int unsigned range_at(bit rear, int ang);
			int a;
			int idx;
			a = ang;
			if (a < -90) a = -90;
			if (a > 90) a = 90;
			idx = (90 - a) / GRANULARITY_DEG;
			if (idx >= MAP_ENTRIES) idx = MAP_ENTRIES - 1;
			return rear ? rear_map[idx] : front_map[idx];
		endfunction

		function bit blocked(bit behind, int unsigned lim);
			int lo;
			int hi;
			bit hit;
			lo = -1;
			hi = 1;
			hit = 0;
			if (steer == STEER_LEFT) begin
				lo = behind ? 0 : -2;
				hi = behind ? 2 : 0;
			end
			if (steer == STEER_RIGHT) begin
				lo = behind ? -2 : 0;
				hi = behind ? 0 : 2;
			end
			for (int i = lo; i <= hi; i++)
				if (range_at(behind, i * SCAN_STEP_DEG) < lim) hit = 1;
			return hit;
		endfunction

		function void ask_speed(int unsigned s);
			if (s != speed_now) speed_goal = s;
		endfunction

		function void steer_to(logic [1:0] d);
			if (steer != d) begin
				steer = d;
				pending = 1;
			end
		endfunction

		function void drive_to(bit rev);
			if (reverse == rev) return;
			if (speed_now != 0) ask_speed(0);
			else begin
				reverse = rev;
				pending = 1;
				tally = 0;
			end
		endfunction

		function void plan_route();
			int unsigned h, d0, l1, l2, r1, r2, a, b;
			bit fwd;
			bit go_back;
			h = cfg_val[4];
			fwd = !reverse;
			if ((fwd && blocked(0, cfg_val[0])) || (!fwd && blocked(1, cfg_val[1]))) begin
				go_back = fwd && !blocked(1, cfg_val[1]);
				steer_to(STEER_NONE);
				if (go_back) drive_to(1);
				else drive_to(0);
			end
			d0 = range_at(reverse, 0);
			l1 = range_at(reverse, -SCAN_STEP_DEG);
			l2 = range_at(reverse, -2 * SCAN_STEP_DEG);
			r1 = range_at(reverse, SCAN_STEP_DEG);
			r2 = range_at(reverse, 2 * SCAN_STEP_DEG);
			if (steer == STEER_LEFT || steer == STEER_RIGHT) begin
				if ((steer == STEER_LEFT) != reverse) begin
					a = l1;
					b = l2;
				end else begin
					a = r1;
					b = r2;
				end
				if (d0 > a + h && d0 > b + h) steer_to(STEER_NONE);
			end else if (steer == STEER_NONE) begin
				if (r1 > d0 + h && r1 > l1 + h) steer_to(reverse ? STEER_LEFT : STEER_RIGHT);
				else if (l1 > d0 + h && l1 > r1 + h)
					steer_to(reverse ? STEER_RIGHT : STEER_LEFT);
			end
		endfunction

		function void note_item(logic [1:0] op, logic [31:0] msg);
			drive_res_t r;
			int idx;
			r = '0;
			if (op == OP_RADAR) begin
				idx = msg[15:8] / GRANULARITY_DEG;
				if (msg[31:24] == CH_R && idx < MAP_ENTRIES) begin
					if (msg[23:16] == CH_F) front_map[idx] = 10 * msg[7:0];
					else if (msg[23:16] == CH_R) rear_map[idx] = 10 * msg[7:0];
				end
				if (tally < 32) tally++;
			end else if (op == OP_PLAN) begin
				if (pending) begin
					r.status_word = {CH_C, reverse ? CH_R : CH_F,
						steer == STEER_LEFT ? CH_L : steer == STEER_RIGHT ? CH_R : CH_N,
						8'(speed_now > 255 ? 255 : speed_now)};
					r.status_valid = 1;
					pending = 0;
				end
				if (tally >= 32) begin
					plan_route();
					if ((!reverse && blocked(0, cfg_val[2])) ||
							(reverse && blocked(1, cfg_val[3]))) begin
						pending = 1;
						reverse = 0;
						steer = STEER_NONE;
						speed_now = 0;
						speed_goal = 0;
						foreach (front_map[i]) begin
							front_map[i] = 0;
							rear_map[i] = 0;
						end
						tally = 0;
						r.emergency = 1;
					end else if (blocked(reverse, reverse ? cfg_val[1] : cfg_val[0]))
						ask_speed(0);
					else if (steer != STEER_NONE) ask_speed(cfg_val[5]);
					else ask_speed(cfg_val[6]);
				end
			end else if (op == OP_RAMP) begin
				if (speed_now < speed_goal) begin
					speed_now += cfg_val[7];
					if (speed_now > speed_goal) speed_now = speed_goal;
					pending = 1;
				end else if (speed_now > speed_goal) begin
					speed_now -= (speed_now < DECEL_STEP) ? speed_now : DECEL_STEP;
					pending = 1;
				end
			end
			r.pwm_level = speed_now[12:0];
			r.drive_reverse = reverse;
			r.steer_state = steer;
			r.warming_up = tally < 32;
			r.motor_stopped = speed_now == 0;
			r.braking = speed_now > speed_goal;
			pending_res.push_back(r);
		endfunction

		function void check_result(drive_res_t got);
			drive_res_t want;
			if (pending_res.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", got);
				return;
			end
			want = pending_res.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: exp %h got %h (sw/sv/pwm/rev/st/em/wu/ms/br)",
						want, got);
			end
		endfunction
	endclass
endpackage

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drive controller testbench: directed and random radar words and ticks,
// register sweeps between phases, results checked against a scoreboard.
// ----------------------------------------------------------------------------
module tb_top;
	import oadc_pkg::*;
	import oadc_tb_pkg::*;

	localparam int WATCHDOG = 2000;

	logic clk = 0;
	logic arst_n = 0;
	oadc_in_if  in_ch ();
	oadc_out_if out_ch ();
	oadc_cfg_if cfg_ch ();

	drive_scoreboard sb;
	int idle_cycles;
	bit running;

	obstacle_avoid_drive_controller_unit u_dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
	);

	always #1 clk = ~clk;

	initial begin
		in_ch.valid = 0;
		in_ch.operation = OP_RADAR;
		in_ch.message = 0;
		out_ch.ready = 0;
		cfg_ch.valid = 0;
		cfg_ch.index = CFG_MAN_AHEAD;
		cfg_ch.data = 0;
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			sb.check_result({out_ch.status_word, out_ch.status_valid, out_ch.pwm_level,
				out_ch.drive_reverse, out_ch.steer_state, out_ch.emergency,
				out_ch.warming_up, out_ch.motor_stopped, out_ch.braking});
	end

	initial begin
		int w;
		@(posedge clk iff arst_n);
		forever begin
			w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
			out_ch.ready <= (w == 0);
			repeat (w) @(posedge clk);
			out_ch.ready <= 1;
			@(posedge clk iff out_ch.valid);
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !running)
			idle_cycles <= 0;
		else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG) begin
				$display("tb_top: errors");
				$finish;
			end
		end
	end

	task automatic send_item(logic [1:0] op, logic [31:0] msg, int gap);
		if (gap > 0) begin
			in_ch.valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1;
		in_ch.operation <= op;
		in_ch.message <= msg;
		@(posedge clk iff in_ch.ready);
		sb.note_item(op, msg);
	endtask

	task automatic write_reg(logic [3:0] idx, logic [12:0] v);
		cfg_ch.valid <= 1;
		cfg_ch.index <= idx;
		cfg_ch.data <= v;
		@(posedge clk iff cfg_ch.ready);
		sb.write_cfg(int'(idx), int'(v));
		cfg_ch.valid <= 0;
		@(posedge clk);
	endtask

	task automatic drain();
		in_ch.valid <= 0;
		@(posedge clk iff sb.pending_res.size() == 0);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [31:0] radar_word(bit rear, int near_bias);
		logic [7:0] ang;
		logic [7:0] rng;
		ang = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
			: 8'($urandom_range(3, 9) * 6 + $urandom_range(0, 5));
		rng = ($urandom_range(0, 99) < near_bias) ? 8'($urandom_range(0, 8))
			: 8'($urandom_range(0, 255));
		return {CH_R, rear ? CH_R : CH_F, ang, rng};
	endfunction

	task automatic random_phase(int n, int near_bias);
		int k;
		logic [31:0] m;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 99);
			if (k < 55) m = radar_word($urandom_range(0, 1), near_bias);
			else if (k < 60) m = $urandom;
			else m = $urandom;
			send_item(k < 60 ? OP_RADAR : k < 80 ? OP_PLAN : k < 97 ? OP_RAMP : OP_UNUSED, m,
				($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 15));
		end
	endtask

	initial begin
		sb = new();
		running = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		running = 1;

		send_item(OP_PLAN, 32'd0, 0);
		send_item(OP_RAMP, 32'd0, 0);
		send_item(OP_UNUSED, 32'hFFFF_FFFF, 0);
		send_item(OP_RADAR, {CH_R, CH_F, 8'd0, 8'd255}, 0);
		send_item(OP_RADAR, {CH_R, CH_R, 8'd191, 8'd0}, 0);
		send_item(OP_RADAR, {CH_R, CH_F, 8'd192, 8'd7}, 0);
		send_item(OP_RADAR, {CH_R, CH_F, 8'd255, 8'd255}, 0);
		send_item(OP_RADAR, {CH_C, CH_F, 8'd90, 8'd1}, 0);
		send_item(OP_RADAR, {CH_R, CH_N, 8'd90, 8'd1}, 0);
		send_item(OP_RADAR, 32'h0, 0);
		for (int i = 0; i < 36; i++)
			send_item(OP_RADAR, {CH_R, i[0] ? CH_R : CH_F, 8'(60 + 6 * (i % 6)), 8'd200}, 0);
		send_item(OP_PLAN, 32'd0, 0);
		for (int i = 0; i < 4; i++) send_item(OP_RAMP, 32'd0, 0);
		send_item(OP_PLAN, 32'd0, 0);
		send_item(OP_RADAR, {CH_R, CH_F, 8'd90, 8'd1}, 0);
		send_item(OP_PLAN, 32'd0, 0);
		drain();

		write_reg(CFG_ACCEL, 13'd0);
		random_phase(60, 20);
		drain();
		write_reg(CFG_MAN_AHEAD, 13'd2550);
		write_reg(CFG_MAN_BEHIND, 13'd0);
		write_reg(CFG_STOP_AHEAD, 13'd0);
		write_reg(CFG_STOP_BEHIND, 13'd2550);
		write_reg(CFG_HYST, 13'd0);
		write_reg(CFG_LOW_SPEED, 13'd6249);
		write_reg(CFG_HIGH_SPEED, 13'd0);
		write_reg(CFG_ACCEL, 13'd6249);
		random_phase(80, 10);
		drain();
		write_reg(CFG_MAN_AHEAD, 13'd0);
		write_reg(CFG_MAN_BEHIND, 13'd2550);
		write_reg(CFG_STOP_AHEAD, 13'd0);
		write_reg(CFG_STOP_BEHIND, 13'd0);
		write_reg(CFG_HYST, 13'd2550);
		write_reg(CFG_LOW_SPEED, 13'd0);
		write_reg(CFG_HIGH_SPEED, 13'd6249);
		write_reg(CFG_ACCEL, 13'd300);
		random_phase(80, 10);
		drain();
		for (int p = 0; p < 3; p++) begin
			write_reg(CFG_MAN_AHEAD, 13'($urandom_range(0, 600)));
			write_reg(CFG_MAN_BEHIND, 13'($urandom_range(0, 600)));
			write_reg(CFG_STOP_AHEAD, 13'($urandom_range(0, 100)));
			write_reg(CFG_STOP_BEHIND, 13'($urandom_range(0, 100)));
			write_reg(CFG_HYST, 13'($urandom_range(0, 200)));
			write_reg(CFG_LOW_SPEED, 13'($urandom_range(0, 6249)));
			write_reg(CFG_HIGH_SPEED, 13'($urandom_range(0, 6249)));
			write_reg(CFG_ACCEL, 13'($urandom_range(0, 800)));
			random_phase(60, 15);
			drain();
		end

		if (sb.mismatches == 0 && sb.pending_res.size() == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end
endmodule
